>>> src/elbs_pkg.sv
// ----------------------------------------------------------------------------
// elbs_pkg
// Shared constants and controller/datapath interface types for the
// exponential lower-bound search core.
// ----------------------------------------------------------------------------
package elbs_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int INDEX_W     = 10;
  localparam int IN_VALUE_W  = 32;
  localparam int POS_W       = 11;
  localparam int LEN_W       = 11;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic load;
    logic start;
    logic dbl_step;
    logic bin_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic dbl_cont;
    logic dbl_more;
    logic bin_more;
  } status_t;

endpackage

>>> src/elbs_ram.sv
// ----------------------------------------------------------------------------
// elbs_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module elbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/elbs_datapath.sv
// ----------------------------------------------------------------------------
// elbs_datapath
// Table memory, length register, key, probe and bracket registers, and the
// result register of the lower-bound search.
// ----------------------------------------------------------------------------
module elbs_datapath #(
  parameter int TABLE_DEPTH = elbs_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = elbs_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  elbs_pkg::cmd_t                cmd,
  output elbs_pkg::status_t             status,
  input  logic                          cfg_valid,
  input  logic [elbs_pkg::LEN_W-1:0]    cfg_data,
  input  logic [elbs_pkg::INDEX_W-1:0]  in_entry_index,
  input  logic [elbs_pkg::IN_VALUE_W-1:0] in_value,
  output logic [elbs_pkg::POS_W-1:0]    out_position
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = IW + 1;

  typedef struct packed {
    logic [IW-1:0] lo;
    logic [IW-1:0] hi;
    logic [IW-1:0] mid;
    logic          more;
  } br_t;

  function automatic br_t bracket(input logic [IW-1:0] lo, input logic [IW-1:0] hi);
    br_t           b;
    logic [IW-1:0] diff;
    diff   = hi - lo;
    b.lo   = lo;
    b.hi   = hi;
    b.mid  = lo + (diff >> 1);
    b.more = (diff > IW'(1));
    return b;
  endfunction

  logic [elbs_pkg::LEN_W-1:0]     array_length_r;
  logic [VALUE_WIDTH-1:0]         key_r;
  logic [IW-1:0]                  n_r;
  logic [IW-1:0]                  probe_r;
  logic [IW-1:0]                  lo_r;
  logic [IW-1:0]                  hi_r;
  logic [IW-1:0]                  mid_r;
  logic [elbs_pkg::POS_W-1:0]     out_pos_r;

  logic [63:0]                    value_ext;
  logic [VALUE_WIDTH-1:0]         value_cut;
  logic [31:0]                    index_ext;
  logic [31:0]                    len_ext;
  logic [31:0]                    hi_ext;
  logic [IW-1:0]                  n_sat;
  logic                           ram_we;
  logic                           ram_re;
  logic [AW-1:0]                  ram_raddr;
  logic [VALUE_WIDTH-1:0]         ram_rdata;
  logic                           lt;
  logic [PW-1:0]                  nxt;
  logic                           nxt_in;
  br_t                            br_dbl_lt;
  br_t                            br_dbl_ge;
  br_t                            br_bin_lt;
  br_t                            br_bin_ge;
  br_t                            dbl_sel;
  br_t                            bin_sel;

  assign value_ext = 64'(in_value);
  assign value_cut = value_ext[VALUE_WIDTH-1:0];
  assign index_ext = 32'(in_entry_index);
  assign len_ext   = 32'(array_length_r);
  assign n_sat     = (len_ext > 32'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH) : IW'(array_length_r);
  assign ram_we    = cmd.load && (index_ext < 32'(TABLE_DEPTH));

  assign lt     = (ram_rdata < key_r);
  assign nxt    = (probe_r == '0) ? PW'(1) : {probe_r, 1'b0};
  assign nxt_in = (nxt < {1'b0, n_r});

  assign br_dbl_lt = bracket(nxt[PW-1:1], nxt_in ? nxt[IW-1:0] : n_r);
  assign br_dbl_ge = bracket(probe_r >> 1, probe_r);
  assign br_bin_lt = bracket(mid_r, hi_r);
  assign br_bin_ge = bracket(lo_r, mid_r);
  assign dbl_sel   = lt ? br_dbl_lt : br_dbl_ge;
  assign bin_sel   = lt ? br_bin_lt : br_bin_ge;

  assign status.len_zero = (array_length_r == '0);
  assign status.dbl_cont = lt && nxt_in;
  assign status.dbl_more = dbl_sel.more;
  assign status.bin_more = bin_sel.more;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (cmd.start) begin
      ram_re = 1'b1;
    end else if (cmd.dbl_step) begin
      ram_re    = 1'b1;
      ram_raddr = status.dbl_cont ? nxt[AW-1:0] : dbl_sel.mid[AW-1:0];
    end else if (cmd.bin_step) begin
      ram_re    = 1'b1;
      ram_raddr = bin_sel.mid[AW-1:0];
    end
  end

  elbs_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (index_ext[AW-1:0]),
    .wdata (value_cut),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      array_length_r <= '0;
    end else if (cfg_valid) begin
      array_length_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r   <= value_cut;
      n_r     <= n_sat;
      probe_r <= '0;
      hi_r    <= '0;
    end else if (cmd.dbl_step) begin
      if (status.dbl_cont) begin
        probe_r <= nxt[IW-1:0];
      end else begin
        lo_r  <= dbl_sel.lo;
        hi_r  <= dbl_sel.hi;
        mid_r <= dbl_sel.mid;
      end
    end else if (cmd.bin_step) begin
      lo_r  <= bin_sel.lo;
      hi_r  <= bin_sel.hi;
      mid_r <= bin_sel.mid;
    end
    if (cmd.emit) begin
      out_pos_r <= hi_ext[elbs_pkg::POS_W-1:0];
    end
  end

  assign hi_ext       = 32'(hi_r);
  assign out_position = out_pos_r;

  a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.start, cmd.dbl_step, cmd.bin_step, cmd.emit}))
    else $error("more than one datapath command at once");

  a_probe_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dbl_step |-> (probe_r < n_r))
    else $error("probe index not below the search length");

  a_mid_in_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bin_step |-> ((lo_r < mid_r) && (mid_r < hi_r) && (hi_r <= n_r)))
    else $error("binary search midpoint outside its bracket");

endmodule

>>> src/elbs_ctrl.sv
// ----------------------------------------------------------------------------
// elbs_ctrl
// Controller: takes requests, steps the doubling and binary phases and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module elbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_kind,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  elbs_pkg::status_t status,
  output elbs_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DBL  = 4'b0010,
    ST_BIN  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;
  logic   slot_free;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == elbs_pkg::KIND_QUERY) begin
            cmd.start = 1'b1;
            state_nxt = status.len_zero ? ST_OUT : ST_DBL;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_DBL: begin
        cmd.dbl_step = 1'b1;
        if (status.dbl_cont) begin
          state_nxt = ST_DBL;
        end else if (status.dbl_more) begin
          state_nxt = ST_BIN;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_BIN: begin
        cmd.bin_step = 1'b1;
        state_nxt    = status.bin_more ? ST_BIN : ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && slot_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished search not handed to the result register");

  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == elbs_pkg::KIND_QUERY && !status.len_zero) |=> (state_r == ST_DBL))
    else $error("query with non-zero length did not enter doubling phase");

  a_bin_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BIN && !status.bin_more) |=> (state_r == ST_OUT))
    else $error("binary phase did not finish on a closed bracket");

endmodule

>>> src/exponential_lower_bound_search_core.sv
// ----------------------------------------------------------------------------
// exponential_lower_bound_search_core
// Lower-bound search over a sorted table by exponential probing followed
// by binary search.
// Load request: no result. Query: reads entry 0, probes beyond entry 0 by
//   doubling the index, then bisects the bracket, with one table read per
//   cycle; the result then waits in the output state for a free slot.
// Zero length: skips both search phases. One request is in work at a
//   time; a held result does not block taking the next request.
// Reset (rst_n, synchronous): controller idle, no result, length 0; table
//   contents undefined until loaded.
// ----------------------------------------------------------------------------
module exponential_lower_bound_search_core #(
  parameter int TABLE_DEPTH = elbs_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = elbs_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [9:0] entry_index, [41:10] value, [47:42] zero
  input  logic [elbs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] kind
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [10:0] position, [15:11] zero
  output logic [elbs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [elbs_pkg::LEN_W-1:0]          cfg_data
);

  elbs_pkg::cmd_t                 cmd;
  elbs_pkg::status_t              status;
  logic [elbs_pkg::POS_W-1:0]     position;

  assign cfg_ready = 1'b1;

  elbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  elbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .in_entry_index (in_tdata[elbs_pkg::INDEX_W-1:0]),
    .in_value       (in_tdata[elbs_pkg::INDEX_W +: elbs_pkg::IN_VALUE_W]),
    .out_position   (position)
  );

  assign out_tdata = {{(elbs_pkg::OUT_TDATA_W - elbs_pkg::POS_W){1'b0}}, position};

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the exponential lower-bound search core. Requests
// (table loads and search queries) are streamed in with bursty gaps while
// the result side stalls on its own pattern and once holds off for a long
// stretch. Each accepted query is scored against a local lower-bound search
// over a shadow copy of the table, and the table length is rewritten
// between phases while the core is idle, from zero up to beyond its depth.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   INDEX_W     = elbs_pkg::INDEX_W;
  localparam int   IN_VALUE_W  = elbs_pkg::IN_VALUE_W;
  localparam int   IN_TDATA_W  = elbs_pkg::IN_TDATA_W;
  localparam int   OUT_TDATA_W = elbs_pkg::OUT_TDATA_W;
  localparam int   POS_W       = elbs_pkg::POS_W;
  localparam int   LEN_W       = elbs_pkg::LEN_W;
  localparam logic KIND_LOAD   = elbs_pkg::KIND_LOAD;
  localparam logic KIND_QUERY  = elbs_pkg::KIND_QUERY;

  localparam int DEPTH = elbs_pkg::TABLE_DEPTH_DEF;
  localparam int PAD_W = IN_TDATA_W - INDEX_W - IN_VALUE_W;

  typedef struct packed {
    logic                  kind;
    logic [INDEX_W-1:0]    entry_index;
    logic [IN_VALUE_W-1:0] value;
  } request_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = KIND_LOAD;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [LEN_W-1:0]       cfg_data   = '0;

  // shadow of the core, updated on accepted requests and length writes
  logic [IN_VALUE_W-1:0] entry_tbl [0:DEPTH-1];
  logic [LEN_W-1:0]      search_len = '0;
  logic [POS_W-1:0]      position_q [$];

  // stimulus side
  request_t              pending [$];
  logic [IN_VALUE_W-1:0] planned_val [0:DEPTH-1];
  int unsigned           burst_left = 1;
  int unsigned           gap_left   = 0;
  int unsigned           query_count = 0;
  int unsigned           fault_count = 0;

  logic [15:0]           stall_pat = 16'hFFFF;
  int unsigned           pat_age   = 0;
  logic                  hold_off  = 1'b0;

  exponential_lower_bound_search_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [POS_W-1:0] lower_bound_of(logic [IN_VALUE_W-1:0] key);
    int unsigned n;
    int unsigned probe;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    n = (search_len > DEPTH) ? DEPTH : search_len;
    if (n == 0) return '0;
    if (entry_tbl[0] >= key) return '0;
    probe = 1;
    while (probe < n && entry_tbl[probe] < key) probe = probe * 2;
    lo = probe / 2;
    hi = (probe < n) ? probe : n;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (entry_tbl[mid] < key) lo = mid;
      else hi = mid;
    end
    return POS_W'(hi);
  endfunction

  task automatic accept_request(input logic kind, input logic [INDEX_W-1:0] idx,
                                input logic [IN_VALUE_W-1:0] val);
    if (kind == KIND_LOAD) begin
      entry_tbl[idx] = val;
    end else begin
      position_q.push_back(lower_bound_of(val));
      query_count++;
    end
  endtask

  task automatic log_fault(input string what, input logic [POS_W-1:0] want,
                           input logic [POS_W-1:0] got);
    fault_count++;
    if (fault_count <= 10)
      $display("%s: expected position %0d, got %0d", what, want, got);
  endtask

  // request driver: hold each request until taken, then advance
  always @(posedge clk) begin : drive_requests
    request_t nxt;
    logic     offer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      offer = in_tvalid;
      if (in_tvalid && in_tready) begin
        accept_request(in_tuser, in_tdata[INDEX_W-1:0],
                       in_tdata[INDEX_W +: IN_VALUE_W]);
        offer = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() != 0) begin
          nxt = pending.pop_front();
          in_tuser <= nxt.kind;
          in_tdata <= {{PAD_W{1'b0}}, nxt.value, nxt.entry_index};
          offer = 1'b1;
        end
      end
      in_tvalid <= offer;
    end
  end

  // result monitor and stall pattern
  always @(posedge clk) begin : watch_results
    logic [POS_W-1:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (position_q.size() == 0) begin
          log_fault("unrequested result", '0, out_tdata[POS_W-1:0]);
        end else begin
          want = position_q.pop_front();
          if (out_tdata[POS_W-1:0] !== want)
            log_fault("position mismatch", want, out_tdata[POS_W-1:0]);
        end
      end
      if (pat_age == 0) begin
        stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
        pat_age   = 32;
      end
      pat_age--;
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      out_tready <= stall_pat[0] && !hold_off;
    end
  end

  // hold off results while queries keep coming, so the core backs up
  initial begin : long_hold
    while (!(query_count >= 40 && pending.size() >= 60)) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic queue_request(input logic kind, input int unsigned idx,
                               input logic [IN_VALUE_W-1:0] val);
    request_t r;
    r.kind        = kind;
    r.entry_index = INDEX_W'(idx);
    r.value       = val;
    if (kind == KIND_LOAD) planned_val[idx] = val;
    pending.push_back(r);
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_tvalid || position_q.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    search_len = len;
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return LEN_W'(DEPTH);
    if (r == 2) return LEN_W'($urandom_range(DEPTH + 1, 2047));
    if (r < 9) return LEN_W'($urandom_range(1, 8));
    if (r < 15) return LEN_W'($urandom_range(9, 64));
    return LEN_W'($urandom_range(65, DEPTH - 1));
  endfunction

  function automatic logic [IN_VALUE_W-1:0] pick_key(logic [LEN_W-1:0] len);
    int unsigned span;
    int unsigned i;
    span = (len == 0 || len > DEPTH) ? DEPTH : len;
    i = $urandom_range(0, span - 1);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      4, 5:    return planned_val[i] - 1;
      6:       return planned_val[i] + 1;
      default: return planned_val[i];
    endcase
  endfunction

  task automatic queue_random_load();
    int unsigned           i;
    logic [IN_VALUE_W-1:0] lo_v;
    logic [IN_VALUE_W-1:0] hi_v;
    i = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63) : $urandom_range(0, DEPTH - 1);
    lo_v = (i == 0) ? '0 : planned_val[i-1];
    hi_v = (i == DEPTH - 1) ? '1 : planned_val[i+1];
    if ($urandom_range(0, 19) == 0 || lo_v > hi_v)
      queue_request(KIND_LOAD, i, $urandom);
    else
      queue_request(KIND_LOAD, i, $urandom_range(hi_v, lo_v));
  endtask

  initial begin : stimulus
    logic [32:0]      acc;
    logic [LEN_W-1:0] len;
    int unsigned      made;
    int unsigned      ph;
    int unsigned      count;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // zero length straight after reset
    queue_request(KIND_QUERY, 0, '0);
    queue_request(KIND_QUERY, DEPTH - 1, '1);

    // small table with duplicates and both value extremes
    queue_request(KIND_LOAD, 0, 32'd0);
    queue_request(KIND_LOAD, 1, 32'd5);
    queue_request(KIND_LOAD, 2, 32'd5);
    queue_request(KIND_LOAD, 3, 32'd9);
    queue_request(KIND_LOAD, 4, 32'd100);
    queue_request(KIND_LOAD, 5, 32'hFFFF_FFFF);
    queue_request(KIND_LOAD, DEPTH - 1, 32'hFFFF_FFFF);
    write_length(LEN_W'(6));
    queue_request(KIND_QUERY, 0, 32'd0);
    queue_request(KIND_QUERY, 1, 32'd1);
    queue_request(KIND_QUERY, 2, 32'd5);
    queue_request(KIND_QUERY, 3, 32'd6);
    queue_request(KIND_QUERY, 4, 32'd9);
    queue_request(KIND_QUERY, 5, 32'd10);
    queue_request(KIND_QUERY, 6, 32'hFFFF_FFFE);
    queue_request(KIND_QUERY, 7, 32'hFFFF_FFFF);
    write_length(LEN_W'(1));
    queue_request(KIND_QUERY, 0, 32'd0);
    queue_request(KIND_QUERY, 1, 32'd1);

    // fill the whole table in ascending order, top entry at the maximum
    acc = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if ($urandom_range(0, 3) != 0) acc = acc + $urandom_range(1, 8_000_000);
      if (acc > 33'hFFFF_FFFF || i == DEPTH - 1) acc = 33'hFFFF_FFFF;
      queue_request(KIND_LOAD, i, acc[31:0]);
    end

    made = 0;
    ph   = 0;
    while (made < 360) begin
      len = (ph == 0) ? LEN_W'(DEPTH) :
            (ph == 1) ? LEN_W'(2047) :
            (ph == 2) ? LEN_W'(1) : pick_length();
      write_length(len);
      count = (ph == 1) ? 200 : $urandom_range(20, 150);
      for (int k = 0; k < count; k++) begin
        if ($urandom_range(0, 4) == 0)
          queue_random_load();
        else
          queue_request(KIND_QUERY, $urandom_range(0, DEPTH - 1), pick_key(len));
      end
      made += count;
      ph++;
    end

    drain();
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
